### rtl/core/otg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otg_pkg
// types, codes and widths shared by the tile origin generator
// ----------------------------------------------------------------------------
package otg_pkg;

    // internal coordinate width, register values are cut to this width
    localparam int COORD_WIDTH = 16;
    // width of config registers and result fields
    localparam int FIELD_WIDTH = 16;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int IN_TDATA_WIDTH = 8;
    localparam int OUT_TDATA_WIDTH = 3 * FIELD_WIDTH;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DONE    = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_TILE_SIDE    = 2'd2,
        CFG_OVERLAP      = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] image_width;
        logic [FIELD_WIDTH-1:0] image_height;
        logic [FIELD_WIDTH-1:0] tile_side;
        logic [FIELD_WIDTH-1:0] overlap_pixels;
    } t_cfg;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] cur_x;
        logic [COORD_WIDTH-1:0] cur_y;
        logic                   plan_active;
    } t_plan_state;

    typedef struct packed {
        t_status                status;
        logic [FIELD_WIDTH-1:0] tile_x;
        logic [FIELD_WIDTH-1:0] tile_y;
        logic [FIELD_WIDTH-1:0] tile_extent;
        logic                   last_tile;
    } t_result;

endpackage
`default_nettype wire

### rtl/core/otg_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otg_cfg_regs
// register file for image size, tile side and overlap
// ----------------------------------------------------------------------------
module otg_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [otg_pkg::CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  wire logic [otg_pkg::FIELD_WIDTH-1:0]   i_cfg_data,
    output otg_pkg::t_cfg                          o_cfg
);

    otg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (otg_pkg::t_cfg_index'(i_cfg_index))
                otg_pkg::CFG_IMAGE_WIDTH:  r_cfg.image_width    <= i_cfg_data;
                otg_pkg::CFG_IMAGE_HEIGHT: r_cfg.image_height   <= i_cfg_data;
                otg_pkg::CFG_TILE_SIDE:    r_cfg.tile_side      <= i_cfg_data;
                otg_pkg::CFG_OVERLAP:      r_cfg.overlap_pixels <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### rtl/core/otg_tile_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otg_tile_step
// next tile origin from the stored origin: one add, compare and clamp per axis
// ----------------------------------------------------------------------------
module otg_tile_step (
    input  wire otg_pkg::t_cfg        i_cfg,
    input  wire logic                 i_restart,
    input  wire otg_pkg::t_plan_state i_state,
    output otg_pkg::t_result          o_result,
    output otg_pkg::t_plan_state      o_next_state
);

    localparam int CW = otg_pkg::COORD_WIDTH;
    localparam int FW = otg_pkg::FIELD_WIDTH;

    logic [CW-1:0] w;
    logic [CW-1:0] h;
    logic [CW-1:0] t;
    logic [CW-1:0] ov;
    logic [CW-1:0] side;
    logic [CW-1:0] step;
    logic [CW-1:0] last_x;
    logic [CW-1:0] last_y;
    logic [CW:0]   sum_x;
    logic [CW:0]   sum_y;
    logic [CW-1:0] nx;
    logic [CW-1:0] ny;
    logic          cfg_ok;
    logic          fin;

    always_comb begin
        w  = CW'(i_cfg.image_width);
        h  = CW'(i_cfg.image_height);
        t  = CW'(i_cfg.tile_side);
        ov = CW'(i_cfg.overlap_pixels);

        side = (w < h) ? w : h;
        side = (t < side) ? t : side;
        cfg_ok = (w != '0) && (h != '0) && (t != '0) && (ov < side);
        step   = side - ov;
        last_x = w - side;
        last_y = h - side;
        sum_x  = {1'b0, i_state.cur_x} + {1'b0, step};
        sum_y  = {1'b0, i_state.cur_y} + {1'b0, step};

        o_result     = '{status: otg_pkg::ST_DONE, default: '0};
        o_next_state = i_state;
        nx  = '0;
        ny  = '0;
        fin = 1'b0;

        if (!i_restart && !i_state.plan_active) begin
            // nothing running: report done, state untouched
        end else if (!cfg_ok) begin
            o_result.status          = otg_pkg::ST_INVALID;
            o_next_state.plan_active = 1'b0;
        end else if (i_restart || (i_state.cur_x < last_x) || (i_state.cur_y < last_y)) begin
            if (i_restart) begin
                nx = '0;
                ny = '0;
            end else if (i_state.cur_x < last_x) begin
                nx = (sum_x < {1'b0, last_x}) ? sum_x[CW-1:0] : last_x;
                ny = i_state.cur_y;
            end else begin
                nx = '0;
                ny = (sum_y < {1'b0, last_y}) ? sum_y[CW-1:0] : last_y;
            end
            fin = (nx == last_x) && (ny == last_y);
            o_result.status          = otg_pkg::ST_OK;
            o_result.tile_x          = FW'(nx);
            o_result.tile_y          = FW'(ny);
            o_result.tile_extent     = FW'(side);
            o_result.last_tile       = fin;
            o_next_state.cur_x       = nx;
            o_next_state.cur_y       = ny;
            o_next_state.plan_active = !fin;
        end else begin
            // both axes at or past their end: plan runs out
            o_next_state.plan_active = 1'b0;
        end
    end

endmodule
`default_nettype wire

### rtl/core/overlapped_tile_origin_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overlapped_tile_origin_generator
// on-demand raster scan of overlapping square tiles over an image
// ----------------------------------------------------------------------------
// Each request on the slave stream gives exactly one result on the master
// stream, one request per clock while the result side is not stalled. A request
// passes an input register, then the tile step logic (one add, compare and
// clamp per axis against the stored origin) and lands in the result register
// together with the updated origin, so back-to-back requests see each
// other's state. tdata bit 0 of a request is restart: 1 starts a new plan at
// origin (0,0), 0 asks for the next tile (x fastest, then y, the last tile
// of each axis clamped flush to the image edge). Results carry the status in
// tuser (ok, invalid configuration, finished or not started), the origin and
// effective side in tdata and the final tile mark in tlast; fields other
// than status are zero when status is not ok. Config registers (width,
// height, tile side, overlap) are written through the config channel, which
// is always ready, and should only change while no request is in flight.
// ----------------------------------------------------------------------------
module overlapped_tile_origin_generator (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // config write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [otg_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [otg_pkg::FIELD_WIDTH-1:0]    i_cfg_data,
    // request stream
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [otg_pkg::IN_TDATA_WIDTH-1:0] i_s_tdata,  // [0] restart, rest zero
    // result stream
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic [otg_pkg::OUT_TDATA_WIDTH-1:0]     o_m_tdata,  // tile_x, tile_y, tile_extent
    output logic [1:0]                              o_m_tuser,  // status
    output logic                                    o_m_tlast   // last_tile
);

    localparam int FW = otg_pkg::FIELD_WIDTH;

    otg_pkg::t_cfg        cfg;
    otg_pkg::t_plan_state r_state;
    otg_pkg::t_plan_state n_state;
    otg_pkg::t_result     n_result;
    otg_pkg::t_result     r_result;

    logic r_in_valid;
    logic r_in_restart;
    logic r_out_valid;
    logic stage_en;
    logic s_fire;
    logic step_fire;

    // config registers, always ready
    assign o_cfg_ready = 1'b1;

    otg_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // result register moves when empty or being drained
    assign stage_en   = !r_out_valid || i_m_tready;
    // input register takes a request when empty or moving on
    assign o_s_tready = !r_in_valid || stage_en;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign step_fire  = r_in_valid && stage_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_restart <= i_s_tdata[0];
        end
    end

    otg_tile_step u_tile_step (
        .i_cfg        (cfg),
        .i_restart    (r_in_restart),
        .i_state      (r_state),
        .o_result     (n_result),
        .o_next_state (n_state)
    );

    // plan state is updated only when a request completes, result valid whenever the result register moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (stage_en) begin
                r_out_valid <= r_in_valid;
            end
            if (step_fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_result.tile_extent, r_result.tile_y, r_result.tile_x};
    assign o_m_tuser  = r_result.status;
    assign o_m_tlast  = r_result.last_tile;

    // a non-ok result carries no tile
    a_not_ok_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != otg_pkg::ST_OK)) |->
            ((o_m_tdata == '0) && !o_m_tlast))
        else $error("non-ok result carries tile data");

    // handing out the final tile closes the plan
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && n_result.last_tile) |=> !r_state.plan_active)
        else $error("plan still active after final tile");

    // an invalid configuration drops the plan
    a_invalid_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && (n_result.status == otg_pkg::ST_INVALID)) |=>
            !r_state.plan_active)
        else $error("plan active after invalid configuration");

    // a good restart puts the origin at the corner
    a_restart_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && r_in_restart && (n_result.status == otg_pkg::ST_OK)) |=>
            ((r_state.cur_x == '0) && (r_state.cur_y == '0) &&
             (r_result.tile_x == FW'(0)) && (r_result.tile_y == FW'(0))))
        else $error("restart did not start at origin");

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the overlapped tile origin generator
// ----------------------------------------------------------------------------
// Restart and next requests are streamed in with random gaps on the request side and
// random stalls on the result side. A behavioral tile planner tracks the
// origin and the running flag and predicts one result per accepted request.
// Results are checked field by field against a FIFO of predictions. The
// config registers are rewritten between phases, only once every result of
// the phase has come back. Some rewrites happen while a plan is still
// running, to cover the axis end moving under a live plan.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;      // pipeline is two deep, keep some margin
    localparam int TOTAL_ITEMS   = 540;    // directed part plus random phases
    localparam int FW            = otg_pkg::FIELD_WIDTH;

    logic                                  i_clk       = 1'b0;
    logic                                  i_rst_n     = 1'b0;
    logic                                  i_cfg_valid = 1'b0;
    logic [otg_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_index = otg_pkg::CFG_IMAGE_WIDTH;
    logic [FW-1:0]                         i_cfg_data  = '0;
    logic                                  i_s_tvalid  = 1'b0;
    logic [otg_pkg::IN_TDATA_WIDTH-1:0]    i_s_tdata   = '0;
    logic                                  i_m_tready  = 1'b0;
    logic                                  o_cfg_ready;
    logic                                  o_s_tready;
    logic                                  o_m_tvalid;
    logic [otg_pkg::OUT_TDATA_WIDTH-1:0]   o_m_tdata;
    logic [1:0]                            o_m_tuser;
    logic                                  o_m_tlast;

    overlapped_tile_origin_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always #2 i_clk = ~i_clk;

    // planner copy of the config registers and the scan state
    logic [FW-1:0] reg_width   = '0;
    logic [FW-1:0] reg_height  = '0;
    logic [FW-1:0] reg_side    = '0;
    logic [FW-1:0] reg_overlap = '0;
    int unsigned   plan_x      = 0;
    int unsigned   plan_y      = 0;
    bit            plan_running = 1'b0;

    bit                 restart_queue[$];   // requests waiting for the driver
    otg_pkg::t_result   expected_tiles[$];  // predicted results in request order
    int                 items_queued  = 0;
    int                 results_seen  = 0;
    int                 mismatches    = 0;
    int                 send_gap      = 0;
    int                 sink_stall    = 0;
    bit                 idle_free     = 1'b0;  // set for phases with no gaps and no stalls
    int                 cycle_count   = 0;
    otg_pkg::t_result   want;

    // next tile of the raster scan, updates the planner state
    function automatic otg_pkg::t_result advance_tile_plan(bit restart);
        otg_pkg::t_result tile;
        int unsigned      w, h, t, ov, side, step, end_x, end_y, nx, ny;
        bit               usable;
        tile        = '0;
        tile.status = otg_pkg::ST_DONE;
        w  = reg_width;
        h  = reg_height;
        t  = reg_side;
        ov = reg_overlap;
        side = t;
        if (w < side) side = w;
        if (h < side) side = h;
        usable = (w != 0) && (h != 0) && (t != 0) && (ov < side);
        // a plain next request with no plan gives finished
        if (!restart && !plan_running) return tile;
        if (!usable) begin
            plan_running = 1'b0;
            tile.status  = otg_pkg::ST_INVALID;
            return tile;
        end
        step  = side - ov;
        end_x = w - side;
        end_y = h - side;
        if (restart) begin
            nx = 0;
            ny = 0;
        end else if (plan_x < end_x) begin
            nx = plan_x + step;
            if (nx > end_x) nx = end_x;
            ny = plan_y;
        end else if (plan_y < end_y) begin
            nx = 0;
            ny = plan_y + step;
            if (ny > end_y) ny = end_y;
        end else begin
            // both axes at or past their end, e.g. after a shrink
            plan_running = 1'b0;
            return tile;
        end
        plan_x       = nx;
        plan_y       = ny;
        plan_running = !((nx == end_x) && (ny == end_y));
        tile.status      = otg_pkg::ST_OK;
        tile.tile_x      = FW'(nx);
        tile.tile_y      = FW'(ny);
        tile.tile_extent = FW'(side);
        tile.last_tile   = !plan_running;
        return tile;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_free || r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // request driver, one request per handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_tiles.insert(expected_tiles.size(),
                                      advance_tile_plan(i_s_tdata[0]));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (restart_queue.size() != 0) begin
                    i_s_tdata  <= {{(otg_pkg::IN_TDATA_WIDTH-1){1'b0}},
                                   restart_queue.pop_front()};
                    i_s_tvalid <= 1'b1;
                    send_gap   = pick_gap();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (expected_tiles.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d x %0d y %0d side %0d last %0d",
                                 o_m_tuser, o_m_tdata[15:0], o_m_tdata[31:16],
                                 o_m_tdata[47:32], o_m_tlast);
                end else begin
                    want = expected_tiles.pop_front();
                    if (want.status != o_m_tuser || want.tile_x != o_m_tdata[15:0] ||
                        want.tile_y != o_m_tdata[31:16] ||
                        want.tile_extent != o_m_tdata[47:32] ||
                        want.last_tile != o_m_tlast) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d mismatch: expected st %0d x %0d y %0d",
                                     results_seen, want.status, want.tile_x, want.tile_y,
                                     " side %0d last %0d,", want.tile_extent,
                                     want.last_tile,
                                     " got st %0d x %0d y %0d side %0d last %0d",
                                     o_m_tuser, o_m_tdata[15:0], o_m_tdata[31:16],
                                     o_m_tdata[47:32], o_m_tlast);
                    end
                end
            end
            if (sink_stall != 0) begin
                sink_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                sink_stall = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_request(bit restart);
        restart_queue.insert(restart_queue.size(), restart);
        items_queued++;
    endtask

    // wait until every request has its result back and the pipe has drained
    task automatic settle();
        wait (results_seen == items_queued);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(otg_pkg::t_cfg_index idx, logic [FW-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            otg_pkg::CFG_IMAGE_WIDTH:  reg_width   = value;
            otg_pkg::CFG_IMAGE_HEIGHT: reg_height  = value;
            otg_pkg::CFG_TILE_SIDE:    reg_side    = value;
            otg_pkg::CFG_OVERLAP:      reg_overlap = value;
            default: ;
        endcase
    endtask

    task automatic load_config(int unsigned w, int unsigned h, int unsigned t,
                               int unsigned ov);
        settle();
        write_reg(otg_pkg::CFG_IMAGE_WIDTH, FW'(w));
        write_reg(otg_pkg::CFG_IMAGE_HEIGHT, FW'(h));
        write_reg(otg_pkg::CFG_TILE_SIDE, FW'(t));
        write_reg(otg_pkg::CFG_OVERLAP, FW'(ov));
    endtask

    initial begin
        int unsigned w, h, t, ov, side, step, end_x, end_y, tiles, plan_len, sel;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // all registers zero after reset: no plan yet, then invalid
        queue_request(1'b0);
        queue_request(1'b1);
        // two tiles on one row, then finished
        load_config(5, 3, 3, 1);
        queue_request(1'b1);
        queue_request(1'b0);
        queue_request(1'b0);
        // shrink the image under a live plan
        load_config(10, 10, 4, 0);
        queue_request(1'b1);
        queue_request(1'b0);
        settle();
        write_reg(otg_pkg::CFG_IMAGE_WIDTH, 16'd4);     // x now past its end, moves to next row
        queue_request(1'b0);
        settle();
        write_reg(otg_pkg::CFG_IMAGE_HEIGHT, 16'd4);    // both axes past their end
        queue_request(1'b0);
        queue_request(1'b0);
        // overlap grows to the side mid-plan: invalid, plan dropped
        load_config(10, 10, 4, 0);
        queue_request(1'b1);
        settle();
        write_reg(otg_pkg::CFG_OVERLAP, 16'd4);
        queue_request(1'b0);
        queue_request(1'b0);
        settle();
        write_reg(otg_pkg::CFG_OVERLAP, 16'hFFFF);
        queue_request(1'b1);
        // full-size image, single tile
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        queue_request(1'b1);
        queue_request(1'b0);
        // large image with clamped final tiles on both axes, 3 x 3 tiles
        load_config(16'hFFFF, 16'hFFFF, 30000, 0);
        queue_request(1'b1);
        repeat (9) queue_request(1'b0);

        // --- random phases ---
        while (items_queued < TOTAL_ITEMS) begin
            settle();
            idle_free = ($urandom_range(0, 4) == 0);
            sel = $urandom_range(0, 19);
            if (sel < 3) begin
                // nudge one register while a plan may still be running
                case ($urandom_range(0, 3))
                    0: write_reg(otg_pkg::CFG_IMAGE_WIDTH, FW'($urandom_range(0, 40)));
                    1: write_reg(otg_pkg::CFG_IMAGE_HEIGHT, FW'($urandom_range(0, 40)));
                    2: write_reg(otg_pkg::CFG_TILE_SIDE, FW'($urandom_range(0, 48)));
                    default: write_reg(otg_pkg::CFG_OVERLAP, FW'($urandom_range(0, 8)));
                endcase
                repeat ($urandom_range(1, 8)) queue_request(1'b0);
            end else if (sel < 5) begin
                // noise: random restart bits on the current setting
                repeat ($urandom_range(1, 12)) queue_request(1'($urandom_range(0, 1)));
            end else begin
                if (sel < 15) begin
                    w = $urandom_range(1, 40);
                    h = $urandom_range(1, 40);
                    t = $urandom_range(1, 48);
                end else if (sel < 19) begin
                    w = $urandom_range(1000, 65535);
                    h = $urandom_range(1000, 65535);
                    t = $urandom_range(((w < h) ? w : h) / 3, 65535);
                end else begin
                    // one register zero
                    w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
                    h = (w != 0 && $urandom_range(0, 1)) ? 0 : $urandom_range(1, 40);
                    t = (w != 0 && h != 0) ? 0 : $urandom_range(1, 48);
                end
                side = t;
                if (w < side) side = w;
                if (h < side) side = h;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: ov = (side == 0) ? 0 : $urandom_range(0, side / 2);
                    6, 7:             ov = (side == 0) ? 0 : $urandom_range(side / 2, side - 1);
                    default:          ov = $urandom_range(side, 65535);
                endcase
                load_config(w, h, t, ov);
                // scan length from the tile counts per axis, capped
                tiles = 1;
                if (side != 0 && ov < side) begin
                    step  = side - ov;
                    end_x = w - side;
                    end_y = h - side;
                    tiles = ((end_x == 0) ? 1 : (end_x + step - 1) / step + 1) *
                            ((end_y == 0) ? 1 : (end_y + step - 1) / step + 1);
                end
                plan_len = (tiles > 30) ? 30 : tiles;
                queue_request(1'b1);
                repeat (plan_len - 1 + $urandom_range(0, 2)) begin
                    // mostly a clean scan, sometimes a stray restart
                    queue_request($urandom_range(0, 19) == 0);
                end
            end
        end

        wait (results_seen == items_queued);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_tiles.size() == 0 && results_seen == items_queued) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
